FILE: design/imufd_pkg.sv
// ----------------------------------------------------------------------------
// imufd_pkg: shared definitions for the imu serial frame decoder
// frame layout bytes, result kind codes and fixed scaling constants
// ----------------------------------------------------------------------------
package imufd_pkg;

	// frame layout
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] TYPE_ACCEL  = 8'h51;
	localparam logic [7:0] TYPE_RATE   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;
	localparam logic [3:0] LAST_POS    = 4'd10;
	localparam int         FIRST_DATA  = 1;
	localparam int         LAST_DATA   = 9;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_RATE  = 2'd1,
		KIND_ANGLE = 2'd2
	} frame_kind_t;

	// axis scale factors, q.16 per raw count
	localparam logic signed [27:0] SCALE_ACCEL = 28'sd32;
	localparam logic signed [27:0] SCALE_RATE  = 28'sd4000;
	localparam logic signed [27:0] SCALE_ANGLE = 28'sd360;

	// temperature: raw * 16384 / 85 as (mag * recip) >> 22, exact for 16-bit mag
	localparam logic [29:0]        TEMP_RECIP  = 30'd808464433;
	localparam int                 TEMP_SHIFT  = 22;
	localparam logic signed [24:0] TEMP_OFFSET = 25'sd2375680;

endpackage

FILE: design/imu_uart_frame_decoder.sv
// ----------------------------------------------------------------------------
// imu_uart_frame_decoder: 11-byte serial imu frame parser
// collects bytes after a 0x55 header and emits scaled q.16 axis and temperature
// ----------------------------------------------------------------------------
// One received byte can be taken every cycle, back to back, while in_stall is
// low. A 0x55 byte always restarts a frame; the eleventh byte closes it. Frames
// of type 0x51 (acceleration), 0x52 (angular rate) or 0x53 (angle) produce one
// result, carried through a capture stage, a stage holding the constant
// multiplies (axis scale and the temperature reciprocal), and the output
// register. Other frame types produce nothing. Input stall rises only when a
// captured frame cannot advance because the stages behind it are full.
module imu_uart_frame_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output imufd_pkg::frame_kind_t      frame_kind,
	output logic signed [27:0]          value_x,
	output logic signed [27:0]          value_y,
	output logic signed [27:0]          value_z,
	output logic signed [24:0]          temperature
);
	import imufd_pkg::*;

	// frame collection state
	logic       in_frame_q;
	logic [3:0] pos_q;
	logic [7:0] frame_q [FIRST_DATA:LAST_DATA];

	// capture stage
	logic               v_s1;
	frame_kind_t        kind_s1;
	logic signed [15:0] raw_x_s1, raw_y_s1, raw_z_s1;
	logic               tneg_s1;
	logic [15:0]        tmag_s1;

	// multiply stage
	logic               v_s2;
	frame_kind_t        kind_s2;
	logic signed [27:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic               tneg_s2;
	logic [22:0]        tquo_s2;

	// output register
	logic               out_valid_q;
	frame_kind_t        kind_q;
	logic signed [27:0] x_q, y_q, z_q;
	logic signed [24:0] temp_q;

	// stage advance
	logic en1, en2, en3, accept;
	assign en3    = !out_valid_q || !out_stall;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept = in_valid && en1;

	// frame close decode
	logic        is_header, closing, known_type;
	frame_kind_t kind_dec;
	always_comb begin
		is_header  = (rx_byte == HEADER_BYTE);
		closing    = in_frame_q && !is_header && (pos_q == LAST_POS);
		known_type = 1'b1;
		case (frame_q[1])
			TYPE_ACCEL: kind_dec = KIND_ACCEL;
			TYPE_RATE:  kind_dec = KIND_RATE;
			TYPE_ANGLE: kind_dec = KIND_ANGLE;
			default: begin
				kind_dec   = KIND_ACCEL;
				known_type = 1'b0;
			end
		endcase
	end

	// position and frame open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 4'd0;
		end else if (accept) begin
			if (is_header) begin
				in_frame_q <= 1'b1;
				pos_q      <= 4'd1;
			end else if (in_frame_q) begin
				if (pos_q == LAST_POS) begin
					in_frame_q <= 1'b0;
					pos_q      <= 4'd0;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	// frame byte store, data bytes only
	always_ff @(posedge clk) begin
		for (int i = FIRST_DATA; i <= LAST_DATA; i++) begin
			if (accept && in_frame_q && !is_header && pos_q == 4'(i))
				frame_q[i] <= rx_byte;
		end
	end

	// capture stage
	logic signed [15:0] raw_t;
	assign raw_t = $signed({frame_q[9], frame_q[8]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && closing && known_type;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1  <= kind_dec;
			raw_x_s1 <= $signed({frame_q[3], frame_q[2]});
			raw_y_s1 <= $signed({frame_q[5], frame_q[4]});
			raw_z_s1 <= $signed({frame_q[7], frame_q[6]});
			tneg_s1  <= raw_t[15];
			tmag_s1  <= raw_t[15] ? 16'(-raw_t) : raw_t;
		end
	end

	// multiply stage
	logic signed [27:0] scale;
	logic [45:0]        tprod;
	always_comb begin
		case (kind_s1)
			KIND_ACCEL: scale = SCALE_ACCEL;
			KIND_RATE:  scale = SCALE_RATE;
			KIND_ANGLE: scale = SCALE_ANGLE;
			default:    scale = SCALE_ACCEL;
		endcase
		tprod = {30'd0, tmag_s1} * {16'd0, TEMP_RECIP};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2   <= kind_s1;
			prod_x_s2 <= {{12{raw_x_s1[15]}}, raw_x_s1} * scale;
			prod_y_s2 <= {{12{raw_y_s1[15]}}, raw_y_s1} * scale;
			prod_z_s2 <= {{12{raw_z_s1[15]}}, raw_z_s1} * scale;
			tneg_s2   <= tneg_s1;
			tquo_s2   <= tprod[TEMP_SHIFT +: 23];
		end
	end

	// temperature sign restore and offset
	logic signed [24:0] tmag_ext, temp_next;
	always_comb begin
		tmag_ext  = $signed({2'b00, tquo_s2});
		temp_next = (tneg_s2 ? -tmag_ext : tmag_ext) + TEMP_OFFSET;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			kind_q <= kind_s2;
			x_q    <= prod_x_s2;
			y_q    <= prod_y_s2;
			z_q    <= prod_z_s2;
			temp_q <= temp_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_kind  = kind_q;
	assign value_x     = x_q;
	assign value_y     = y_q;
	assign value_z     = z_q;
	assign temperature = temp_q;

endmodule
